// ----- src/aes_pkg.sv -----
// shared types, tables and round functions of the aes block cipher unit
`timescale 1ns / 1ps
package aes_pkg;

    localparam int NumCells  = 14;
    localparam int NumRkeys  = 15;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_KEY0 = 3'd1;
    localparam logic [2:0] REG_KEY1 = 3'd2;
    localparam logic [2:0] REG_KEY2 = 3'd3;
    localparam logic [2:0] REG_KEY3 = 3'd4;

    localparam logic [7:0] RED_POLY = 8'h1b;

    typedef logic [NumRkeys-1:0][3:0][31:0] t_rkeys;
    typedef logic [3:0][63:0]               t_key;

    typedef struct packed {
        logic valid;
        logic decrypt;
    } t_cell_ctl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? RED_POLY : 8'h00);
    endfunction

    function automatic logic [3:0] rounds_of(input logic [1:0] mode);
        return mode[1] ? 4'd14 : (mode[0] ? 4'd12 : 4'd10);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte b of the state sits at [127-8b -: 8], byte c*4+r is row r of column c
    function automatic logic [127:0] sub_fwd(input logic [127:0] s);
        logic [127:0] o;
        for (int b = 0; b < 16; b++) begin
            o[127-8*b -: 8] = SBOX[s[127-8*b -: 8]];
        end
        return o;
    endfunction

    function automatic logic [127:0] sub_inv(input logic [127:0] s);
        logic [127:0] o;
        for (int b = 0; b < 16; b++) begin
            o[127-8*b -: 8] = INV_SBOX[s[127-8*b -: 8]];
        end
        return o;
    endfunction

    function automatic logic [127:0] shift_fwd(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127-8*(c*4+r) -: 8] = s[127-8*((((c+r)&3)*4)+r) -: 8];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] shift_inv(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127-8*((((c+r)&3)*4)+r) -: 8] = s[127-8*(c*4+r) -: 8];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_fwd(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a [4];
        logic [7:0]   x2 [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = s[127-8*(c*4+k) -: 8];
                x2[k] = xtime(a[k]);
            end
            for (int r = 0; r < 4; r++) begin
                o[127-8*(c*4+r) -: 8] = x2[r] ^ x2[(r+1)&3] ^ a[(r+1)&3]
                                      ^ a[(r+2)&3] ^ a[(r+3)&3];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_inv(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = s[127-8*(c*4+k) -: 8];
                x2[k] = xtime(a[k]);
                x4[k] = xtime(x2[k]);
                x8[k] = xtime(x4[k]);
            end
            // 14, 11, 13, 9 along the row
            for (int r = 0; r < 4; r++) begin
                o[127-8*(c*4+r) -: 8] = (x8[r] ^ x4[r] ^ x2[r])
                    ^ (x8[(r+1)&3] ^ x2[(r+1)&3] ^ a[(r+1)&3])
                    ^ (x8[(r+2)&3] ^ x4[(r+2)&3] ^ a[(r+2)&3])
                    ^ (x8[(r+3)&3] ^ a[(r+3)&3]);
            end
        end
        return o;
    endfunction

endpackage

// ----- src/aes_key_sched.sv -----
// key expansion sequencer, one schedule word per cycle into the round key store
`timescale 1ns / 1ps
module aes_key_sched (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_restart,
    input  logic [1:0]     i_mode,
    input  aes_pkg::t_key  i_key,
    output logic           o_busy,
    output aes_pkg::t_rkeys o_rk_enc,
    output aes_pkg::t_rkeys o_rk_dec
);
    import aes_pkg::*;

    logic            r_active;
    logic [5:0]      r_idx;
    logic [2:0]      r_mod;
    logic [7:0]      r_rc;
    logic [7:0][31:0] r_win;
    t_rkeys          r_enc;
    t_rkeys          r_dec;

    logic [3:0]  nr;
    logic [3:0]  nk;
    logic [5:0]  last_idx;
    logic [63:0] kpair;
    logic [31:0] old_w;
    logic [31:0] tmp;
    logic [31:0] n_word;
    logic        in_key;
    logic        rc_step;
    logic [3:0]  dec_slot;

    always_comb begin
        nr       = rounds_of(i_mode);
        nk       = nr - 4'd6;
        last_idx = {nr, 2'b11};
        in_key   = (r_idx < {2'b00, nk});
        kpair    = i_key[r_idx[2:1]];
        case (i_mode)
            MODE_128: old_w = r_win[4];
            MODE_192: old_w = r_win[2];
            default:  old_w = r_win[0];
        endcase
        rc_step = !in_key && (r_mod == 3'd0);
        if (rc_step) begin
            tmp = sub_word({r_win[7][23:0], r_win[7][31:24]}) ^ {r_rc, 24'h000000};
        end else if (i_mode[1] && r_mod == 3'd4) begin
            tmp = sub_word(r_win[7]);
        end else begin
            tmp = r_win[7];
        end
        n_word   = in_key ? (r_idx[0] ? kpair[31:0] : kpair[63:32]) : (old_w ^ tmp);
        dec_slot = nr - r_idx[5:2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_active <= 1'b1;
            r_idx    <= '0;
            r_mod    <= '0;
            r_rc     <= 8'h01;
        end else if (r_active) begin
            r_idx <= r_idx + 6'd1;
            r_mod <= (r_mod == nk[2:0] - 3'd1) ? 3'd0 : r_mod + 3'd1;
            if (rc_step) begin
                r_rc <= xtime(r_rc);
            end
            if (r_idx == last_idx) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_win <= {n_word, r_win[7:1]};
            r_enc[r_idx[5:2]][2'd3 - r_idx[1:0]] <= n_word;
            r_dec[dec_slot][2'd3 - r_idx[1:0]]   <= n_word;
        end
    end

    assign o_busy   = r_active;
    assign o_rk_enc = r_enc;
    assign o_rk_dec = r_dec;

endmodule

// ----- src/aes_round_cell.sv -----
// one cipher round cell of the pipeline, encrypt or decrypt per request
`timescale 1ns / 1ps
module aes_round_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_round,
    input  logic [3:0]         i_nr,
    input  aes_pkg::t_cell_ctl i_ctl,
    input  logic [127:0]       i_state,
    input  logic [127:0]       i_key_enc,
    input  logic [127:0]       i_key_dec,
    output aes_pkg::t_cell_ctl o_ctl,
    output logic [127:0]       o_state
);
    import aes_pkg::*;

    t_cell_ctl    r_ctl;
    logic [127:0] r_state;
    logic [127:0] n_state;
    logic [127:0] e_t;
    logic [127:0] d_t;
    logic         last;

    always_comb begin
        last = (i_round == i_nr);
        e_t  = shift_fwd(sub_fwd(i_state));
        if (!last) begin
            e_t = mix_fwd(e_t);
        end
        d_t = sub_inv(shift_inv(i_state)) ^ i_key_dec;
        if (!last) begin
            d_t = mix_inv(d_t);
        end
        n_state = i_ctl.decrypt ? d_t : (e_t ^ i_key_enc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_state <= n_state;
    end

    assign o_ctl   = r_ctl;
    assign o_state = r_state;

endmodule

// ----- src/aes_block_encrypt_decrypt_unit.sv -----
// top level of the pipelined aes-128/192/256 block encrypt and decrypt unit
`timescale 1ns / 1ps
// usage:
// - configuration over the apb port: mode at 0x00, key words 0..3 at 0x08..0x20,
//   64-bit data, byte 0 of each key word in the top bits; reads return the value
// - any register write restarts the key expansion; busy stays high meanwhile,
//   for 128-, 192- or 256-bit keys alike (one schedule word a cycle)
// - after reset the expansion also runs once, on the all-zero 128-bit key
// - a request is taken when start is high and busy is low; i_command picks
//   encrypt (0) or decrypt (1), the block comes on i_block_high / i_block_low
// - one request per cycle while busy is low, back to back: a chain of 14 round cells, each cell
//   does one round and hands its state to the next every cycle
// - a request passes the entry register, the round cells up to round nr of the
//   key length and the output register, in that order
// - results come in request order with o_valid high for one cycle;
//   the receiver cannot stall, so nothing holds the chain
// - config writes only while no request is in flight
module aes_block_encrypt_decrypt_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    // result channel
    output logic        o_valid,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);
    import aes_pkg::*;

    // configuration registers
    logic [1:0]  r_mode;
    t_key        r_key;
    logic        wr_en;
    logic [2:0]  reg_idx;
    logic        restart;

    // key store
    logic        ks_busy;
    t_rkeys      rk_enc;
    t_rkeys      rk_dec;
    logic [3:0]  nr;

    // pipeline
    t_cell_ctl    r_s0_ctl;
    logic [127:0] r_s0_state;
    t_cell_ctl    cell_ctl   [NumCells+1];
    logic [127:0] cell_state [NumCells+1];
    logic         r_out_valid;
    logic [127:0] r_out_state;
    logic         accept;

    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign restart = wr_en && (reg_idx inside {[REG_MODE:REG_KEY3]});
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_128;
            r_key  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE: r_mode   <= pwdata[1:0];
                REG_KEY0: r_key[0] <= pwdata;
                REG_KEY1: r_key[1] <= pwdata;
                REG_KEY2: r_key[2] <= pwdata;
                REG_KEY3: r_key[3] <= pwdata;
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE: prdata = {62'd0, r_mode};
            REG_KEY0: prdata = r_key[0];
            REG_KEY1: prdata = r_key[1];
            REG_KEY2: prdata = r_key[2];
            REG_KEY3: prdata = r_key[3];
            default:  prdata = '0;
        endcase
    end

    aes_key_sched u_key_sched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_mode    (r_mode),
        .i_key     (r_key),
        .o_busy    (ks_busy),
        .o_rk_enc  (rk_enc),
        .o_rk_dec  (rk_dec)
    );

    assign busy   = ks_busy;
    assign accept = start && !ks_busy;
    assign nr     = rounds_of(r_mode);

    // entry stage: first round key add (round 0 for encrypt, round nr for decrypt)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
        end else begin
            r_s0_ctl.valid   <= accept;
            r_s0_ctl.decrypt <= i_command;
        end
        r_s0_state <= {i_block_high, i_block_low}
                    ^ (i_command ? rk_dec[0] : rk_enc[0]);
    end

    assign cell_ctl[0]   = r_s0_ctl;
    assign cell_state[0] = r_s0_state;

    for (genvar g = 1; g <= NumCells; g++) begin : g_cell
        aes_round_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_round   (4'(g)),
            .i_nr      (nr),
            .i_ctl     (cell_ctl[g-1]),
            .i_state   (cell_state[g-1]),
            .i_key_enc (rk_enc[g]),
            .i_key_dec (rk_dec[g]),
            .o_ctl     (cell_ctl[g]),
            .o_state   (cell_state[g])
        );
    end

    // tap the chain after the last round of the configured key length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            case (r_mode)
                MODE_128: r_out_valid <= cell_ctl[10].valid;
                MODE_192: r_out_valid <= cell_ctl[12].valid;
                default:  r_out_valid <= cell_ctl[14].valid;
            endcase
        end
        case (r_mode)
            MODE_128: r_out_state <= cell_state[10];
            MODE_192: r_out_state <= cell_state[12];
            default:  r_out_state <= cell_state[14];
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_result_high = r_out_state[127:64];
    assign o_result_low  = r_out_state[63:0];

endmodule

// ----- bench/aes_block_encrypt_decrypt_unit_tb.sv -----
// testbench of the aes block encrypt and decrypt unit: known vectors and random blocks
`timescale 1ns / 1ps
module aes_block_encrypt_decrypt_unit_tb;
    import aes_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        i_command;
    logic [63:0] i_block_high;
    logic [63:0] i_block_low;
    logic        o_valid;
    logic [63:0] o_result_high;
    logic [63:0] o_result_low;

    aes_block_encrypt_decrypt_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .i_command(i_command),
        .i_block_high(i_block_high), .i_block_low(i_block_low),
        .o_valid(o_valid), .o_result_high(o_result_high), .o_result_low(o_result_low)
    );

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_blk;

    typedef struct {
        logic [2:0]  reg_idx;   // key setting applied before the row, REG_MODE row carries it
        logic        do_cfg;
        logic [1:0]  mode;
        logic [63:0] k0, k1, k2, k3;
        logic        cmd;
        logic [63:0] bh, bl;
        logic        known;     // expected block typed in
        logic [63:0] eh, el;
    } t_row;

    // shadow of the configuration registers
    logic [1:0]  cfg_mode;
    logic [63:0] cfg_key [4];

    t_blk        block_fifo [$];
    int          mismatches;
    bit          failed;
    logic [7:0]  sbox_tab [256];
    logic [7:0]  isbox_tab [256];

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = gf_dbl(a);
        end
        return p;
    endfunction

    // the s-box built from the field inverse and the affine map
    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] inv, r;
        inv = 8'h00;
        for (int c = 1; c < 256; c++) begin
            if (gf_mul(x, c[7:0]) == 8'h01) inv = c[7:0];
        end
        for (int i = 0; i < 8; i++) begin
            r[i] = inv[i] ^ inv[(i+4)%8] ^ inv[(i+5)%8] ^ inv[(i+6)%8] ^ inv[(i+7)%8];
        end
        return r ^ 8'h63;
    endfunction

    // one block through the cipher with the current shadow key
    function automatic t_blk cipher_block(input logic cmd, input logic [63:0] bh,
                                          input logic [63:0] bl);
        logic [31:0] w [60];
        logic [7:0]  s [16];
        logic [7:0]  t [16];
        logic [7:0]  col [4];
        logic [7:0]  m [4];
        logic [31:0] x;
        logic [7:0]  rc;
        int          nk, nr, rnd;
        t_blk        res;
        nk = cfg_mode[1] ? 8 : (cfg_mode[0] ? 6 : 4);
        nr = nk + 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++) begin
            w[i] = (i & 1) ? cfg_key[i>>1][31:0] : cfg_key[i>>1][63:32];
        end
        for (int i = nk; i < 4*(nr+1); i++) begin
            x = w[i-1];
            if (i % nk == 0) begin
                x = {x[23:0], x[31:24]};
                x = {sbox_tab[x[31:24]], sbox_tab[x[23:16]], sbox_tab[x[15:8]],
                     sbox_tab[x[7:0]]} ^ {rc, 24'h0};
                rc = gf_dbl(rc);
            end else if (nk == 8 && i % nk == 4) begin
                x = {sbox_tab[x[31:24]], sbox_tab[x[23:16]], sbox_tab[x[15:8]],
                     sbox_tab[x[7:0]]};
            end
            w[i] = w[i-nk] ^ x;
        end
        for (int i = 0; i < 8; i++) begin
            s[i]   = bh[63-8*i -: 8];
            s[i+8] = bl[63-8*i -: 8];
        end
        if (cmd == CMD_DEC) begin
            m = '{8'd14, 8'd11, 8'd13, 8'd9};
        end else begin
            m = '{8'd2, 8'd3, 8'd1, 8'd1};
        end
        for (int step = 0; step <= nr; step++) begin
            rnd = (cmd == CMD_DEC) ? nr - step : step;
            if (step > 0) begin
                // byte substitution and row shift, the order does not matter
                for (int i = 0; i < 16; i++) begin
                    t[i] = (cmd == CMD_DEC) ? isbox_tab[s[i]] : sbox_tab[s[i]];
                end
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) begin
                        if (cmd == CMD_DEC) s[((c+r)&3)*4+r] = t[c*4+r];
                        else s[c*4+r] = t[((c+r)&3)*4+r];
                    end
                end
                // forward mixes before the key, inverse after it
                if (cmd == CMD_ENC && step < nr) begin
                    for (int c = 0; c < 4; c++) begin
                        for (int k = 0; k < 4; k++) col[k] = s[c*4+k];
                        for (int r = 0; r < 4; r++) begin
                            s[c*4+r] = 8'h00;
                            for (int k = 0; k < 4; k++) s[c*4+r] ^= gf_mul(col[k], m[(k-r+4)&3]);
                        end
                    end
                end
            end
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) s[c*4+r] ^= w[rnd*4+c][31-8*r -: 8];
            end
            if (cmd == CMD_DEC && step > 0 && step < nr) begin
                for (int c = 0; c < 4; c++) begin
                    for (int k = 0; k < 4; k++) col[k] = s[c*4+k];
                    for (int r = 0; r < 4; r++) begin
                        s[c*4+r] = 8'h00;
                        for (int k = 0; k < 4; k++) s[c*4+r] ^= gf_mul(col[k], m[(k-r+4)&3]);
                    end
                end
            end
        end
        for (int i = 0; i < 8; i++) begin
            res.hi[63-8*i -: 8] = s[i];
            res.lo[63-8*i -: 8] = s[i+8];
        end
        return res;
    endfunction

    // apb write, setup then access; the unit goes busy to rebuild its key schedule
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE: cfg_mode   = val[1:0];
            REG_KEY0: cfg_key[0] = val;
            REG_KEY1: cfg_key[1] = val;
            REG_KEY2: cfg_key[2] = val;
            REG_KEY3: cfg_key[3] = val;
            default: ;
        endcase
    endtask

    // wait until every expected block has arrived, then for the pipeline to drain
    task automatic drain_pipe;
        start <= 1'b0;
        while (block_fifo.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_key(input logic [1:0] mode, input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
        drain_pipe();
        reg_write(REG_MODE, {62'h0, mode});
        reg_write(REG_KEY0, k0);
        reg_write(REG_KEY1, k1);
        reg_write(REG_KEY2, k2);
        reg_write(REG_KEY3, k3);
    endtask

    // hand one request over, waiting out busy
    task automatic send_block(input logic cmd, input logic [63:0] bh, input logic [63:0] bl);
        start        <= 1'b1;
        i_command    <= cmd;
        i_block_high <= bh;
        i_block_low  <= bl;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        block_fifo.push_back(cipher_block(cmd, bh, bl));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // result checker, samples at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        t_blk exp_blk;
        if (i_rst_n && o_valid) begin
            if (block_fifo.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %h", o_result_high, o_result_low);
            end else begin
                exp_blk = block_fifo.pop_front();
                if (o_result_high !== exp_blk.hi || o_result_low !== exp_blk.lo) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h, got %h %h",
                                 exp_blk.hi, exp_blk.lo, o_result_high, o_result_low);
                end
            end
        end
    end

    t_row rows [$];

    initial begin
        t_blk        chk;
        logic [63:0] kr [4];
        int          n_sent;
        logic        cmd;
        logic [63:0] bh, bl;

        mismatches = 0;
        failed     = 1'b0;
        for (int i = 0; i < 256; i++) sbox_tab[i] = sbox_calc(i[7:0]);
        for (int i = 0; i < 256; i++) isbox_tab[sbox_tab[i]] = i[7:0];
        cfg_mode = MODE_128;
        for (int i = 0; i < 4; i++) cfg_key[i] = 64'h0;

        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        start = 1'b0; i_command = CMD_ENC; i_block_high = '0; i_block_low = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: fips-197 vectors, the all-zero key after reset, extremes
        rows = '{
            // after reset, zero key, zero block
            '{REG_MODE, 1'b0, MODE_128, 64'h0, 64'h0, 64'h0, 64'h0,
              CMD_ENC, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
            '{REG_MODE, 1'b0, MODE_128, 64'h0, 64'h0, 64'h0, 64'h0,
              CMD_ENC, '1, '1, 1'b0, 64'h0, 64'h0},
            '{REG_MODE, 1'b0, MODE_128, 64'h0, 64'h0, 64'h0, 64'h0,
              CMD_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 64'h0, 64'h0},
            // 128-bit key, appendix c vector
            '{REG_MODE, 1'b1, MODE_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1,
              CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff,
              1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
            '{REG_MODE, 1'b0, MODE_128, 64'h0, 64'h0, 64'h0, 64'h0,
              CMD_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a,
              1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff},
            // 192-bit key, unused key bytes set
            '{REG_MODE, 1'b1, MODE_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
              64'h1011121314151617, '1,
              CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff,
              1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191},
            '{REG_MODE, 1'b0, MODE_128, 64'h0, 64'h0, 64'h0, 64'h0,
              CMD_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191,
              1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff},
            // 256-bit key
            '{REG_MODE, 1'b1, MODE_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
              64'h1011121314151617, 64'h18191a1b1c1d1e1f,
              CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff,
              1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089},
            '{REG_MODE, 1'b0, MODE_128, 64'h0, 64'h0, 64'h0, 64'h0,
              CMD_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089,
              1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff},
            // key length mode three acts as a 256-bit key
            '{REG_MODE, 1'b1, 2'd3, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
              64'h1011121314151617, 64'h18191a1b1c1d1e1f,
              CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff,
              1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089},
            '{REG_MODE, 1'b0, MODE_128, 64'h0, 64'h0, 64'h0, 64'h0,
              CMD_DEC, '1, 64'h0, 1'b0, 64'h0, 64'h0},
            // all-ones key in each length
            '{REG_MODE, 1'b1, MODE_128, '1, '1, '1, '1, CMD_ENC, '1, '1, 1'b0, 64'h0, 64'h0},
            '{REG_MODE, 1'b0, MODE_128, 64'h0, 64'h0, 64'h0, 64'h0,
              CMD_DEC, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
            '{REG_MODE, 1'b1, MODE_192, '1, '1, '1, 64'h0, CMD_ENC, 64'h0, '1, 1'b0, 64'h0, 64'h0},
            '{REG_MODE, 1'b0, MODE_128, 64'h0, 64'h0, 64'h0, 64'h0,
              CMD_DEC, '1, '1, 1'b0, 64'h0, 64'h0},
            '{REG_MODE, 1'b1, MODE_256, '1, '1, '1, '1, CMD_ENC, '1, 64'h0, 1'b0, 64'h0, 64'h0},
            '{REG_MODE, 1'b0, MODE_128, 64'h0, 64'h0, 64'h0, 64'h0,
              CMD_DEC, 64'h8000000000000000, 64'h1, 1'b0, 64'h0, 64'h0}
        };
        foreach (rows[i]) begin
            if (rows[i].do_cfg) begin
                set_key(rows[i].mode, rows[i].k0, rows[i].k1, rows[i].k2, rows[i].k3);
            end
            chk = cipher_block(rows[i].cmd, rows[i].bh, rows[i].bl);
            if (rows[i].known && (chk.hi !== rows[i].eh || chk.lo !== rows[i].el)) begin
                // typed-in vector disagrees with the predictor: fail the run
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: expected %h %h, got %h %h",
                             i, rows[i].eh, rows[i].el, chk.hi, chk.lo);
            end
            send_block(rows[i].cmd, rows[i].bh, rows[i].bl);
            if ($urandom_range(0, 1)) idle_cycles($urandom_range(1, 3));
        end
        idle_cycles(1);

        // random part, a new random key every phase
        n_sent = 0;
        for (int ph = 0; ph < 16; ph++) begin
            for (int k = 0; k < 4; k++) kr[k] = {$urandom, $urandom};
            set_key(2'($urandom_range(0, 3)), kr[0], kr[1], kr[2], kr[3]);
            for (int j = 0; j < 100; j++) begin
                cmd = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0:       begin bh = '1; bl = {$urandom, $urandom}; end
                    1:       begin bh = {$urandom, $urandom}; bl = '0; end
                    default: begin bh = {$urandom, $urandom}; bl = {$urandom, $urandom}; end
                endcase
                send_block(cmd, bh, bl);
                n_sent++;
                // bursts with random gaps, long back-to-back stretches in odd phases
                if (ph % 2 == 0 && $urandom_range(0, 7) == 0) begin
                    idle_cycles($urandom_range(1, 16));
                end
                if (j == 50 && ph == 3) begin
                    start <= 1'b0;
                    while (block_fifo.size() != 0) @(posedge i_clk);
                end
            end
            idle_cycles(1);
        end

        drain_pipe();
        if (!failed && block_fifo.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/aes_pkg.sv
src/aes_key_sched.sv
src/aes_round_cell.sv
src/aes_block_encrypt_decrypt_unit.sv
bench/aes_block_encrypt_decrypt_unit_tb.sv
